// File: src/clti_pkg.sv
// Shared types and constants for the cubic Lagrange table interpolator.
// Used by clti_muldiv, the top level and the port checker; no dependencies.
`default_nettype none
package clti_pkg;

	localparam int unsigned PROD_W = 96;
	localparam int unsigned W_W    = 63;
	localparam int unsigned W_FRAC = 30;

	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_ORDER = 3'd1;
	localparam logic [2:0] STAT_EMPTY = 3'd2;
	localparam logic [2:0] STAT_FULL  = 3'd3;
	localparam logic [2:0] STAT_SAT   = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WRD, ST_WCHK, ST_BASE, ST_TRDI, ST_TGETI,
		ST_FCHK, ST_FGET, ST_FWAIT, ST_TERM, ST_TWAIT, ST_FIN
	} state_t;

	typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV} unit_state_t;

	typedef struct packed {
		logic start;
		logic do_div;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] res;
	} md_rsp_t;

endpackage
`default_nettype wire

// File: src/clti_muldiv.sv
// Bit-serial multiply-add followed by an optional restoring division.
// Depends on clti_pkg for widths and the request and response structs.
`default_nettype none
module clti_muldiv (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire clti_pkg::md_req_t       req,
	input  wire logic [clti_pkg::W_W-1:0] a,
	input  wire logic [32:0]             b,
	input  wire logic [33:0]             c,
	input  wire logic [32:0]             d,
	output clti_pkg::md_rsp_t            rsp
);
	import clti_pkg::*;

	unit_state_t       ust_q;
	logic [6:0]        cnt_q;
	logic              div_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] ash_q;
	logic [32:0]       b_q;
	logic [32:0]       d_q;
	logic [32:0]       r_q;
	logic              done_q;
	logic [33:0]       rs;
	logic              ge;

	assign rs = {r_q, acc_q[PROD_W-1]};
	assign ge = rs >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ust_q  <= U_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (ust_q)
				U_IDLE: begin
					if (req.start) begin
						ust_q <= U_MUL;
						cnt_q <= '0;
					end
				end
				U_MUL: begin
					if (cnt_q == 7'd32) begin
						cnt_q <= '0;
						if (div_q) ust_q <= U_DIV;
						else begin
							ust_q  <= U_IDLE;
							done_q <= 1'b1;
						end
					end else cnt_q <= cnt_q + 7'd1;
				end
				U_DIV: begin
					if (cnt_q == 7'(PROD_W - 1)) begin
						ust_q  <= U_IDLE;
						done_q <= 1'b1;
					end else cnt_q <= cnt_q + 7'd1;
				end
				default: ust_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ust_q)
			U_IDLE: begin
				if (req.start) begin
					acc_q <= PROD_W'(c);
					ash_q <= PROD_W'(a);
					b_q   <= b;
					d_q   <= d;
					div_q <= req.do_div;
					r_q   <= '0;
				end
			end
			U_MUL: begin
				if (b_q[0]) acc_q <= acc_q + ash_q;
				ash_q <= {ash_q[PROD_W-2:0], 1'b0};
				b_q   <= {1'b0, b_q[32:1]};
			end
			U_DIV: begin
				// Quotient bits shift in behind the dividend as it leaves.
				r_q   <= ge ? 33'(rs - {1'b0, d_q}) : rs[32:0];
				acc_q <= {acc_q[PROD_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.res  = acc_q;

endmodule
`default_nettype wire

// File: src/cubic_lagrange_table_interp.sv
// Top level: point table memories, cursor walk and Lagrange sequencer.
// Depends on clti_pkg and clti_muldiv.
//
//  channel  | handshake           | fields
//  request  | start, busy         | func, abscissa, ordinate, restart
//  result   | done (one cycle)    | interp_value, status
//
// A load returns its result in the cycle after acceptance and never raises busy.
// A query walks the cursor (above four points) with a read and a compare state
// per step, then builds each weight factor on the shared multiply-divide unit
// as a multiply-add and a division, and each term as one more multiply-add.
// Reset empties the table and clears the cursor; no clearing pass is run.
// The receiver cannot stall; each result shows for exactly one cycle.
`default_nettype none
module cubic_lagrange_table_interp #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [31:0] abscissa,
	input  wire logic [31:0] ordinate,
	input  wire logic        restart,
	output logic             done,
	output logic [31:0]      interp_value,
	output logic [2:0]       status
);
	import clti_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [31:0] mem_x [TABLE_DEPTH];
	logic [31:0] mem_y [TABLE_DEPTH];
	logic [31:0] rd_x_q, rd_y_q;
	logic [AW-1:0] rd_addr;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, cursor_q, base_q;
	logic [31:0]   last_x_q, xx_q, xi_q, yi_q;
	logic [2:0]    m_q, i_q, j_q;
	logic [W_W-1:0] w_q;
	logic          neg_q, sat_q;
	logic signed [63:0] sum_q;
	logic          done_q;
	logic [31:0]   value_q;
	logic [2:0]    status_q;

	md_req_t req;
	md_rsp_t rsp;
	logic [W_W-1:0] u_a;
	logic [32:0] u_b, u_d;
	logic [33:0] u_c;

	logic accept, is_load;
	logic signed [32:0] d1, d2;
	logic [32:0] ad1, ad2, ay;
	logic [CW-1:0] cur_base, base_lim;
	logic [PROD_W-1:0] q_full;
	logic [65:0] t_full;
	logic [60:0] t_sat;

	assign accept  = start && !busy;
	assign is_load = !func;
	assign busy    = state_q != ST_IDLE;

	assign d1  = $signed({xx_q[31], xx_q}) - $signed({rd_x_q[31], rd_x_q});
	assign d2  = $signed({xi_q[31], xi_q}) - $signed({rd_x_q[31], rd_x_q});
	assign ad1 = d1[32] ? 33'(-d1) : 33'(d1);
	assign ad2 = d2[32] ? 33'(-d2) : 33'(d2);
	assign ay  = yi_q[31] ? 33'(-$signed({yi_q[31], yi_q})) : {1'b0, yi_q};

	assign cur_base = (cursor_q >= CW'(2)) ? cursor_q - CW'(2) : '0;
	assign base_lim = count_q - CW'(4);
	assign q_full   = rsp.res;
	assign t_full   = rsp.res[PROD_W-1:W_FRAC];
	assign t_sat    = (t_full > 66'(61'd1 << 60)) ? (61'd1 << 60) : t_full[60:0];

	always_ff @(posedge clk) begin
		if (accept && is_load && !(count_q >= DEPTH_C && !restart)
		    && !(!restart && count_q != '0 && $signed(abscissa) <= $signed(last_x_q))) begin
			mem_x[restart ? '0 : count_q[AW-1:0]] <= abscissa;
			mem_y[restart ? '0 : count_q[AW-1:0]] <= ordinate;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !is_load && count_q != '0)
					state_d = (count_q <= CW'(4)) ? ST_TRDI : ST_WRD;
			end
			ST_WRD:   state_d = (cursor_q == count_q) ? ST_BASE : ST_WCHK;
			ST_WCHK:  state_d = ($signed(xx_q) > $signed(rd_x_q)) ? ST_WRD : ST_BASE;
			ST_BASE:  state_d = ST_TRDI;
			ST_TRDI:  state_d = ST_TGETI;
			ST_TGETI: state_d = ST_FCHK;
			ST_FCHK: begin
				if (j_q == m_q) state_d = ST_TERM;
				else if (j_q != i_q) state_d = ST_FGET;
			end
			ST_FGET:  state_d = ST_FWAIT;
			ST_FWAIT: if (rsp.done) state_d = ST_FCHK;
			ST_TERM:  state_d = ST_TWAIT;
			ST_TWAIT: if (rsp.done) state_d = (i_q + 3'd1 == m_q) ? ST_FIN : ST_TRDI;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_addr    = cursor_q[AW-1:0];
		req.start  = 1'b0;
		req.do_div = 1'b0;
		u_a = w_q;
		u_b = ad1;
		u_c = 34'(ad2[32:1]);
		u_d = ad2;
		unique case (state_q)
			ST_TRDI: rd_addr = AW'(base_q + CW'(i_q));
			ST_FCHK: rd_addr = AW'(base_q + CW'(j_q));
			ST_FGET: begin
				req.start  = 1'b1;
				req.do_div = 1'b1;
			end
			ST_TERM: begin
				req.start = 1'b1;
				u_b = ay;
				u_c = 34'(1) << (W_FRAC - 1);
			end
			default: ;
		endcase
	end

	clti_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .req(req),
		.a(u_a), .b(u_b), .c(u_c), .d(u_d), .rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (accept) begin
				if (is_load) begin
					done_q <= 1'b1;
					if (restart) cursor_q <= '0;
					if (count_q >= DEPTH_C && !restart) ;
					else if (!restart && count_q != '0
					         && $signed(abscissa) <= $signed(last_x_q)) ;
					else count_q <= restart ? CW'(1) : count_q + CW'(1);
				end else begin
					if (restart) cursor_q <= '0;
					if (count_q == '0) done_q <= 1'b1;
				end
			end
			if (state_q == ST_WCHK && $signed(xx_q) > $signed(rd_x_q))
				cursor_q <= cursor_q + CW'(1);
			if (state_q == ST_FIN) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xx_q     <= abscissa;
			value_q  <= '0;
			status_q <= STAT_OK;
			sat_q    <= 1'b0;
			sum_q    <= '0;
			i_q      <= '0;
			base_q   <= '0;
			m_q      <= 3'(count_q);
			if (is_load) begin
				if (count_q >= DEPTH_C && !restart) status_q <= STAT_FULL;
				else if (!restart && count_q != '0
				         && $signed(abscissa) <= $signed(last_x_q)) status_q <= STAT_ORDER;
				else last_x_q <= abscissa;
			end else if (count_q == '0) status_q <= STAT_EMPTY;
			else if (count_q > CW'(4)) m_q <= 3'd4;
		end
		case (state_q)
			ST_BASE: base_q <= (cur_base > base_lim) ? base_lim : cur_base;
			ST_TGETI: begin
				xi_q  <= rd_x_q;
				yi_q  <= rd_y_q;
				w_q   <= W_W'(1) << W_FRAC;
				neg_q <= 1'b0;
				j_q   <= '0;
			end
			ST_FCHK: if (j_q == i_q) j_q <= j_q + 3'd1;
			ST_FGET: if (d1[32] != d2[32]) neg_q <= !neg_q;
			ST_FWAIT: begin
				if (rsp.done) begin
					j_q <= j_q + 3'd1;
					if (q_full > PROD_W'(W_W'(1) << 62)) begin
						w_q   <= W_W'(1) << 62;
						sat_q <= 1'b1;
					end else w_q <= q_full[W_W-1:0];
				end
			end
			ST_TWAIT: begin
				if (rsp.done) begin
					i_q <= i_q + 3'd1;
					if (t_full > 66'(61'd1 << 60)) sat_q <= 1'b1;
					if (neg_q ^ yi_q[31]) sum_q <= sum_q - $signed({3'b000, t_sat});
					else sum_q <= sum_q + $signed({3'b000, t_sat});
				end
			end
			ST_FIN: begin
				if (sum_q > 64'sd2147483647) begin
					value_q  <= 32'h7FFF_FFFF;
					status_q <= STAT_SAT;
				end else if (sum_q < -64'sd2147483648) begin
					value_q  <= 32'h8000_0000;
					status_q <= STAT_SAT;
				end else begin
					value_q  <= sum_q[31:0];
					status_q <= sat_q ? STAT_SAT : STAT_OK;
				end
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign interp_value = value_q;
	assign status       = status_q;

endmodule
`default_nettype wire

// File: src/clti_checker.sv
// Port-level checks for cubic_lagrange_table_interp, bound to the top level.
// Depends on clti_pkg for the status codes.
`default_nettype none
module clti_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        func,
	input wire logic        done,
	input wire logic [31:0] interp_value,
	input wire logic [2:0]  status
);
	import clti_pkg::*;

	// A load request always answers in the next cycle without going busy.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !func |=> done && !busy)
		else $error("load request not answered next cycle");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= STAT_SAT)
		else $error("status code out of range");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_ORDER || status == STAT_EMPTY || status == STAT_FULL)
		|-> interp_value == 32'd0)
		else $error("nonzero value with error status");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("query finished without a result");

endmodule

bind cubic_lagrange_table_interp clti_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
	.done(done), .interp_value(interp_value), .status(status)
);
`default_nettype wire

// File: dv/tb_cubic_lagrange_table_interp.sv
// Self-checking testbench for cubic_lagrange_table_interp: table loads and
// Lagrange queries, checked against an in-bench predictor. Needs clti_pkg.
`timescale 1ns / 1ps
module tb_cubic_lagrange_table_interp;
	import clti_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [63:0] WEIGHT_MAX = 64'd1 << 62;
	localparam logic [127:0] TERM_MAX = 128'd1 << 60;
	localparam logic FN_LOAD = 1'b0;
	localparam logic FN_QUERY = 1'b1;

	typedef struct {
		logic signed [31:0] value;
		logic [2:0] stat;
	} interp_result_t;

	class interp_scoreboard;
		logic signed [31:0] xs [DEPTH];
		logic signed [31:0] ys [DEPTH];
		int unsigned count;
		int unsigned cursor;
		interp_result_t pending_q [$];
		int errors;
		int loads, queries, saturated;

		function new();
			count = 0;
			cursor = 0;
			errors = 0;
			loads = 0;
			queries = 0;
			saturated = 0;
		endfunction

		function logic [63:0] mag(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		function logic signed [31:0] cubic_at(int unsigned base, int unsigned m,
				logic signed [31:0] xx, inout bit sat);
			longint sum;
			logic [63:0] w, a2;
			logic [127:0] num, q, p, t;
			longint d1, d2;
			bit neg;
			sum = 0;
			for (int i = 0; i < m; i++) begin
				w = 64'd1 << W_FRAC;
				neg = 0;
				for (int j = 0; j < m; j++) begin
					if (j != i) begin
						d1 = longint'(xx) - longint'(xs[base + j]);
						d2 = longint'(xs[base + i]) - longint'(xs[base + j]);
						if ((d1 < 0) != (d2 < 0))
							neg = !neg;
						a2 = mag(d2);
						num = 128'(w) * 128'(mag(d1)) + 128'(a2 >> 1);
						q = num / 128'(a2);
						if (q > 128'(WEIGHT_MAX)) begin
							sat = 1;
							w = WEIGHT_MAX;
						end else
							w = q[63:0];
					end
				end
				if (ys[base + i] < 0)
					neg = !neg;
				p = 128'(mag(longint'(ys[base + i]))) * 128'(w) + (128'd1 << (W_FRAC - 1));
				t = p >> W_FRAC;
				if (t > TERM_MAX) begin
					sat = 1;
					t = TERM_MAX;
				end
				sum += neg ? -longint'(t[63:0]) : longint'(t[63:0]);
			end
			if (sum > 64'sd2147483647) begin
				sat = 1;
				return 32'h7fffffff;
			end
			if (sum < -64'sd2147483648) begin
				sat = 1;
				return 32'h80000000;
			end
			return sum[31:0];
		endfunction

		// Called once per accepted request; updates the table and queues the result.
		function void note(logic fn, logic signed [31:0] x, logic signed [31:0] y, logic rs);
			interp_result_t r;
			bit sat;
			int unsigned base;
			r.value = 0;
			r.stat = STAT_OK;
			if (fn == FN_LOAD) begin
				loads++;
				if (rs) begin
					count = 0;
					cursor = 0;
				end
				if (count >= DEPTH)
					r.stat = STAT_FULL;
				else if (count > 0 && x <= xs[count - 1])
					r.stat = STAT_ORDER;
				else begin
					xs[count] = x;
					ys[count] = y;
					count++;
				end
			end else begin
				queries++;
				if (rs)
					cursor = 0;
				if (count == 0)
					r.stat = STAT_EMPTY;
				else begin
					sat = 0;
					if (count <= 4)
						r.value = cubic_at(0, count, x, sat);
					else begin
						if (cursor > count)
							cursor = count;
						while (cursor < count && x > xs[cursor])
							cursor++;
						base = cursor >= 2 ? cursor - 2 : 0;
						if (base > count - 4)
							base = count - 4;
						r.value = cubic_at(base, 4, x, sat);
					end
					if (sat) begin
						r.stat = STAT_SAT;
						saturated++;
					end
				end
			end
			pending_q.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check(logic signed [31:0] v, logic [2:0] s);
			interp_result_t e;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result value=%h status=%0d", v, s));
				return;
			end
			e = pending_q.pop_front();
			if (v !== e.value)
				report($sformatf("interp_value %h, expected %h", v, e.value));
			if (s !== e.stat)
				report($sformatf("status %0d, expected %0d", s, e.stat));
		endtask
	endclass

	logic clk, arst_n, start, func, restart;
	logic [31:0] abscissa, ordinate;
	wire logic busy, done;
	wire logic [31:0] interp_value;
	wire logic [2:0] status;
	interp_scoreboard sb;
	bit no_gaps;

	cubic_lagrange_table_interp dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.abscissa(abscissa), .ordinate(ordinate), .restart(restart), .done(done),
		.interp_value(interp_value), .status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check(interp_value, status);

	task send(logic fn, logic [31:0] x, logic [31:0] y, logic rs);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		func <= fn;
		abscissa <= x;
		ordinate <= y;
		restart <= rs;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note(fn, x, y, rs);
	endtask

	task drain();
		start <= 0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	function logic [31:0] rand_ordinate();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 200000)) - 100000);
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
		endcase
	endfunction

	initial begin
		longint x, lo_x, hi_x, step;
		int k, nq, items;
		sb = new();
		no_gaps = 0;
		arst_n = 0;
		start = 0;
		func = FN_LOAD;
		abscissa = 0;
		ordinate = 0;
		restart = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty table, extremes, order errors, small tables, a full one.
		send(FN_QUERY, 32'h0, 32'h0, 0);
		send(FN_LOAD, 32'h80000000, 32'h7fffffff, 1);
		send(FN_QUERY, 32'h7fffffff, 32'hffffffff, 1);
		send(FN_LOAD, 32'h80000000, 32'h1, 0);
		send(FN_LOAD, 32'h7fffffff, 32'h80000000, 0);
		send(FN_QUERY, 32'h80000000, 32'h0, 0);
		send(FN_QUERY, 32'h0, 32'h0, 0);
		send(FN_LOAD, 32'h00010000, 32'h00020000, 1);
		send(FN_LOAD, 32'h00010001, 32'h7fffffff, 0);
		send(FN_LOAD, 32'h00010001, 32'h0, 0);
		send(FN_LOAD, 32'h00020000, 32'h80000000, 0);
		// Far extrapolation through close points drives every stage into saturation.
		send(FN_QUERY, 32'h7fffffff, 32'h0, 0);
		send(FN_LOAD, 32'h00030000, 32'h00050000, 0);
		send(FN_QUERY, 32'h00018000, 32'h0, 0);
		drain();
		for (int i = 0; i < DEPTH + 2; i++)
			send(FN_LOAD, 32'(i * 65536 - 2000000), rand_ordinate(), i == 0);
		send(FN_QUERY, 32'(40 * 65536 - 2000000), 32'h0, 0);
		send(FN_QUERY, 32'(-3000000), 32'h0, 0);
		send(FN_QUERY, 32'(5 * 65536 - 2000000), 32'h0, 1);
		send(FN_QUERY, 32'h7fffffff, 32'h0, 0);
		drain();

		items = 0;
		while (items < 1560) begin
			no_gaps = $urandom_range(0, 3) == 0;
			k = $urandom_range(0, 15) == 0 ? $urandom_range(40, 66) : $urandom_range(1, 10);
			lo_x = $urandom_range(0, 3) == 0 ? longint'($signed($urandom))
				: longint'($signed($urandom_range(0, 400000))) - 200000;
			x = lo_x;
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(0, 9) == 0)
					send(FN_LOAD, $urandom, rand_ordinate(), 0);
				else begin
					send(FN_LOAD, 32'(x), rand_ordinate(), i == 0);
					hi_x = x;
					case ($urandom_range(0, 3))
						0: step = $urandom_range(1, 16);
						1: step = $urandom >> $urandom_range(4, 12);
						default: step = $urandom_range(1000, 200000);
					endcase
					x += step;
				end
				items++;
			end
			nq = $urandom_range(1, 5);
			for (int i = 0; i < nq; i++) begin
				if ($urandom_range(0, 4) == 0)
					x = longint'($signed($urandom));
				else
					x = lo_x + longint'($urandom_range(0, 1000))
						* ((hi_x - lo_x + 2000) / 1000) - 1000;
				send(FN_QUERY, 32'(x), $urandom, $urandom_range(0, 5) == 0);
				items++;
			end
			if ($urandom_range(0, 19) == 0)
				drain();
		end

		drain();
		repeat (50) @(posedge clk);
		$display("Covered %0d loads and %0d queries, %0d of them saturated.",
			sb.loads, sb.queries, sb.saturated);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
